[sv/slt_pkg.sv]
// Shared types, result codes and keyword table for the stack language tokenizer.
`default_nettype none
package slt_pkg;

    typedef logic [3:0] t_kind;

    localparam t_kind KIND_LETTER  = 4'd0;
    localparam t_kind KIND_LABEL   = 4'd1;
    localparam t_kind KIND_REF     = 4'd2;
    localparam t_kind KIND_INT     = 4'd3;
    localparam t_kind KIND_CMD     = 4'd4;
    localparam t_kind KIND_BADCH   = 4'd5;
    localparam t_kind KIND_NOCOLON = 4'd6;
    localparam t_kind KIND_NODIGIT = 4'd7;
    localparam t_kind KIND_UNKCMD  = 4'd8;

    localparam int unsigned NUM_KEYWORDS = 21;
    localparam int unsigned MAX_WORD     = 6;

    // Keywords packed first letter high, right-aligned.
    localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
        48'h616464, 48'h737562, 48'h6d756c, 48'h646976, 48'h6a6d70,
        48'h6a6571, 48'h6a6e71, 48'h6a6774, 48'h6a6c74, 48'h676574,
        48'h736574, 48'h647570, 48'h706f70, 48'h70706f73, 48'h73697a65,
        48'h73776170, 48'h646267, 48'h7072696e74, 48'h637072696e74,
        48'h72656164, 48'h6372656164
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4, 3'd5
    };

    // Byte classes worked out by the front end.
    typedef struct packed {
        logic blank;
        logic lf;
        logic hash;
        logic stop;     // zero byte or byte of 128 or more
        logic colon;
        logic at;
        logic minus;
        logic digit;
        logic letter;
    } t_cls;

    typedef struct packed {
        logic       eot;
        logic [7:0] char_byte;
        t_cls       cls;
    } t_qitem;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  int_value;
        logic [4:0]   command_code;
        logic [7:0]   name_letter;
        logic [15:0]  token_line;
        logic [15:0]  token_column;
        logic         last;
    } t_res;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_kw;

    function automatic t_kw kw_lookup(input logic [47:0] word, input logic [2:0] len);
        t_kw r;
        r = '0;
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (KW_TEXT[i] == word && KW_LEN[i] == len) begin
                r.hit  = 1'b1;
                r.code = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic t_res mk_res(input t_kind kind, input logic [31:0] value,
                                    input logic [4:0] code, input logic [7:0] letter,
                                    input logic [15:0] ln, input logic [15:0] col);
        t_res r;
        r.kind         = kind;
        r.int_value    = value;
        r.command_code = code;
        r.name_letter  = letter;
        r.token_line   = ln;
        r.token_column = col;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/stack_language_tokenizer.sv]
// Top level of the stack language tokenizer.
`default_nettype none
// Lexer for a small stack language, fed one source byte per item. It skips
// blanks and '#' comments, tracks line and column, and reports labels
// (':name:') and references ('@name'), letters reported one by one for
// both, signed decimal integers that wrap, and 21 command keywords. A byte with
// i_end_of_text set flushes the pending token and returns the lexer to its
// start state. After an error, or a zero or non-ASCII byte at a token start,
// bytes are dropped until end of input. Rate: one byte per cycle in, one
// result per cycle out, while i_ready is high. A byte enters a two-entry
// queue, the lexer takes one byte per cycle from it whenever the four-entry
// result queue has room for two results, and results leave that queue one
// per cycle while i_ready is high, so a stream whose bytes cause at most one
// result each runs at one byte per cycle; bytes that cause two results (a
// token ended by a bad character) are bounded by the output port at one
// result per cycle. o_last_of_run marks the final result of a byte.
module stack_language_tokenizer #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_kind,
    output logic signed [31:0] o_int_value,
    output logic [4:0]       o_command_code,
    output logic [7:0]       o_name_letter,
    output logic [15:0]      o_token_line,
    output logic [15:0]      o_token_column,
    output logic             o_last_of_run
);
    import slt_pkg::*;

    // Classified bytes between the front end and the lexer.
    t_qitem item;
    logic   item_valid;
    logic   item_take;

    slt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_byte   (i_char_byte),
        .i_end_of_text (i_end_of_text),
        .o_item        (item),
        .o_item_valid  (item_valid),
        .i_item_take   (item_take)
    );

    // Lexer and result queue.
    slt_back #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_item_valid   (item_valid),
        .o_item_take    (item_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_int_value    (o_int_value),
        .o_command_code (o_command_code),
        .o_name_letter  (o_name_letter),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_last_of_run  (o_last_of_run)
    );
endmodule
`default_nettype wire

[sv/slt_queue.sv]
// Small synchronous FIFO between the byte front end and the lexer.
`default_nettype none
module slt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_head, r_tail;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_data  = r_mem[r_head];

    function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) r_tail <= bump(r_tail);
            if (pop)  r_head <= bump(r_head);
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end
endmodule
`default_nettype wire

[sv/slt_front.sv]
// Front end: accepts source bytes, classifies them and queues them for the lexer.
`default_nettype none
module slt_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_text,
    output slt_pkg::t_qitem  o_item,
    output logic             o_item_valid,
    input  wire logic        i_item_take
);
    import slt_pkg::*;

    t_qitem                 in_item;
    logic [$bits(t_qitem)-1:0] q_data;
    logic                   full, empty;
    logic [7:0]             c;

    assign c = i_char_byte;

    always_comb begin
        in_item.eot        = i_end_of_text;
        in_item.char_byte  = c;
        in_item.cls.lf     = (c == 8'h0A);
        in_item.cls.blank  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        in_item.cls.hash   = (c == 8'h23);
        in_item.cls.stop   = (c == 8'h00) || c[7];
        in_item.cls.colon  = (c == 8'h3A);
        in_item.cls.at     = (c == 8'h40);
        in_item.cls.minus  = (c == 8'h2D);
        in_item.cls.digit  = (c >= 8'h30) && (c <= 8'h39);
        in_item.cls.letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    end

    slt_queue #(
        .WIDTH ($bits(t_qitem)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (in_item),
        .o_full  (full),
        .i_pop   (i_item_take),
        .o_data  (q_data),
        .o_empty (empty)
    );

    assign o_ready      = !full;
    assign o_item       = t_qitem'(q_data);
    assign o_item_valid = !empty;
endmodule
`default_nettype wire

[sv/slt_back.sv]
// Back end: lexer state machine and the result queue.
`default_nettype none
module slt_back #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire slt_pkg::t_qitem i_item,
    input  wire logic        i_item_valid,
    output logic             o_item_take,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_kind,
    output logic signed [31:0] o_int_value,
    output logic [4:0]       o_command_code,
    output logic [7:0]       o_name_letter,
    output logic [15:0]      o_token_line,
    output logic [15:0]      o_token_column,
    output logic             o_last_of_run
);
    import slt_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int PW = POSITION_WIDTH;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_LABEL   = 3'd2;
    localparam logic [2:0] MODE_REF     = 3'd3;
    localparam logic [2:0] MODE_SIGN    = 3'd4;
    localparam logic [2:0] MODE_DIGITS  = 3'd5;
    localparam logic [2:0] MODE_WORD    = 3'd6;
    localparam logic [2:0] MODE_HALT    = 3'd7;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_IW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    logic [2:0]    r_mode, n_mode;
    logic [47:0]   r_buf, n_buf;
    logic [2:0]    r_len, n_len;
    logic          r_long, n_long;
    logic [VW-1:0] r_acc, n_acc;
    logic          r_neg, n_neg;
    logic [PW-1:0] r_line, n_line, r_col, n_col, r_sline, n_sline, r_scol, n_scol;

    logic          take, do_adv, idle_go, do_rst, va, vb, matched;
    t_res          res_a, res_b, wr0, wr1;
    t_kw           kw;
    t_cls          cl;
    logic [7:0]    c;
    logic [VW-1:0] ival;
    logic [31:0]   ival32;
    logic [15:0]   cur_ln, cur_col, st_ln, st_col;

    t_res             r_oq [OQ_DEPTH];
    logic [OQ_IW-1:0] r_head, r_tail;
    logic [OQ_CW-1:0] r_cnt;
    logic             pop;
    logic [1:0]       npush;

    assign c       = i_item.char_byte;
    assign cl      = i_item.cls;
    assign take    = i_item_valid && (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign o_item_take = take;

    assign cur_ln  = 16'(r_line);
    assign cur_col = 16'(r_col);
    assign st_ln   = 16'(r_sline);
    assign st_col  = 16'(r_scol);

    assign ival    = r_neg ? (VW'(0) - r_acc) : r_acc;
    assign ival32  = 32'(signed'(ival));
    assign kw      = kw_lookup(r_buf, r_len);
    assign matched = !r_long && kw.hit;

    always_comb begin
        n_mode  = r_mode;
        n_buf   = r_buf;
        n_len   = r_len;
        n_long  = r_long;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_line  = r_line;
        n_col   = r_col;
        va      = 1'b0;
        vb      = 1'b0;
        res_a   = '0;
        res_b   = '0;
        do_adv  = 1'b0;
        idle_go = 1'b0;
        do_rst  = 1'b0;

        if (take) begin
            if (i_item.eot) begin
                do_rst = 1'b1;
                unique case (r_mode)
                    MODE_LABEL: begin
                        va = 1'b1;
                        res_a = mk_res(KIND_NOCOLON, '0, '0, '0, cur_ln, cur_col);
                    end
                    MODE_REF: begin
                        va = 1'b1;
                        res_a = mk_res(KIND_REF, '0, '0, '0, st_ln, st_col);
                    end
                    MODE_SIGN: begin
                        va = 1'b1;
                        res_a = mk_res(KIND_NODIGIT, '0, '0, '0, cur_ln, cur_col);
                    end
                    MODE_DIGITS: begin
                        va = 1'b1;
                        res_a = mk_res(KIND_INT, ival32, '0, '0, st_ln, st_col);
                    end
                    MODE_WORD: begin
                        va = 1'b1;
                        res_a = matched ? mk_res(KIND_CMD, '0, kw.code, '0, st_ln, st_col)
                                        : mk_res(KIND_UNKCMD, '0, '0, '0, st_ln, st_col);
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_mode)
                    MODE_HALT: ;
                    MODE_COMMENT: begin
                        if (cl.lf) n_mode = MODE_IDLE;
                        do_adv = 1'b1;
                    end
                    MODE_LABEL: begin
                        va = 1'b1;
                        if (cl.letter) begin
                            res_a = mk_res(KIND_LETTER, '0, '0, c, st_ln, st_col);
                            do_adv = 1'b1;
                        end else if (cl.colon) begin
                            res_a = mk_res(KIND_LABEL, '0, '0, '0, st_ln, st_col);
                            do_adv = 1'b1;
                            n_mode = MODE_IDLE;
                        end else begin
                            res_a = mk_res(KIND_NOCOLON, '0, '0, '0, cur_ln, cur_col);
                            n_mode = MODE_HALT;
                        end
                    end
                    MODE_REF: begin
                        va = 1'b1;
                        if (cl.letter) begin
                            res_a = mk_res(KIND_LETTER, '0, '0, c, st_ln, st_col);
                            do_adv = 1'b1;
                        end else begin
                            res_a = mk_res(KIND_REF, '0, '0, '0, st_ln, st_col);
                            idle_go = 1'b1;
                        end
                    end
                    MODE_SIGN: begin
                        if (cl.digit) begin
                            n_acc  = VW'(c[3:0]);
                            n_mode = MODE_DIGITS;
                            do_adv = 1'b1;
                        end else begin
                            va = 1'b1;
                            res_a = mk_res(KIND_NODIGIT, '0, '0, '0, cur_ln, cur_col);
                            n_mode = MODE_HALT;
                        end
                    end
                    MODE_DIGITS: begin
                        if (cl.digit) begin
                            // acc * 10 + digit, wrapping
                            n_acc  = (r_acc << 3) + (r_acc << 1) + VW'(c[3:0]);
                            do_adv = 1'b1;
                        end else begin
                            va = 1'b1;
                            res_a = mk_res(KIND_INT, ival32, '0, '0, st_ln, st_col);
                            idle_go = 1'b1;
                        end
                    end
                    MODE_WORD: begin
                        if (cl.letter) begin
                            if (r_len < 3'(MAX_WORD)) begin
                                n_buf = {r_buf[39:0], c};
                                n_len = r_len + 3'd1;
                            end else begin
                                n_long = 1'b1;
                            end
                            do_adv = 1'b1;
                        end else begin
                            va = 1'b1;
                            if (matched) begin
                                res_a = mk_res(KIND_CMD, '0, kw.code, '0, st_ln, st_col);
                                idle_go = 1'b1;
                            end else begin
                                res_a = mk_res(KIND_UNKCMD, '0, '0, '0, st_ln, st_col);
                                n_mode = MODE_HALT;
                            end
                        end
                    end
                    default: idle_go = 1'b1;
                endcase

                // Byte handled as the start of something new.
                if (idle_go) begin
                    n_mode = MODE_IDLE;
                    if (cl.blank) begin
                        do_adv = 1'b1;
                    end else if (cl.hash) begin
                        n_mode = MODE_COMMENT;
                        do_adv = 1'b1;
                    end else if (cl.stop) begin
                        n_mode = MODE_HALT;
                    end else if (cl.colon || cl.at) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_mode  = cl.colon ? MODE_LABEL : MODE_REF;
                        do_adv  = 1'b1;
                    end else if (cl.minus || cl.digit) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_neg   = cl.minus;
                        n_acc   = cl.minus ? '0 : VW'(c[3:0]);
                        n_mode  = cl.minus ? MODE_SIGN : MODE_DIGITS;
                        do_adv  = 1'b1;
                    end else if (cl.letter) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_buf   = {40'd0, c};
                        n_len   = 3'd1;
                        n_long  = 1'b0;
                        n_mode  = MODE_WORD;
                        do_adv  = 1'b1;
                    end else begin
                        vb = 1'b1;
                        res_b = mk_res(KIND_BADCH, '0, '0, c, cur_ln, cur_col);
                        n_mode = MODE_HALT;
                    end
                end
            end
        end

        if (do_adv) begin
            if (cl.lf) begin
                n_line = r_line + 1'b1;
                n_col  = PW'(1);
            end else begin
                n_col  = r_col + 1'b1;
            end
        end

        if (do_rst) begin
            n_mode  = MODE_IDLE;
            n_buf   = '0;
            n_len   = '0;
            n_long  = 1'b0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_line  = PW'(1);
            n_col   = PW'(1);
            n_sline = PW'(1);
            n_scol  = PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_buf   <= '0;
            r_len   <= '0;
            r_long  <= 1'b0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_line  <= PW'(1);
            r_col   <= PW'(1);
            r_sline <= PW'(1);
            r_scol  <= PW'(1);
        end else begin
            r_mode  <= n_mode;
            r_buf   <= n_buf;
            r_len   <= n_len;
            r_long  <= n_long;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

    // Result queue: up to two writes per cycle, one read.
    always_comb begin
        wr0 = va ? res_a : res_b;
        wr1 = res_b;
        wr0.last = !(va && vb);
        wr1.last = 1'b1;
    end

    assign npush = {1'b0, va} + {1'b0, vb};
    assign pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (npush != 2'd0) r_oq[r_tail] <= wr0;
        if (npush == 2'd2) r_oq[r_tail + 1'b1] <= wr1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + OQ_IW'(npush);
            if (pop) r_head <= r_head + 1'b1;
            r_cnt  <= r_cnt + OQ_CW'(npush) - OQ_CW'(pop);
        end
    end

    assign o_valid        = (r_cnt != '0);
    assign o_kind         = r_oq[r_head].kind;
    assign o_int_value    = signed'(r_oq[r_head].int_value);
    assign o_command_code = r_oq[r_head].command_code;
    assign o_name_letter  = r_oq[r_head].name_letter;
    assign o_token_line   = r_oq[r_head].token_line;
    assign o_token_column = r_oq[r_head].token_column;
    assign o_last_of_run  = r_oq[r_head].last;

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OQ_CW'(OQ_DEPTH))
        else $error("result queue overfilled");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.eot) |=> (r_mode == MODE_IDLE && r_line == PW'(1) && r_col == PW'(1)))
        else $error("end of input did not return lexer to start");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_item.eot && r_mode == MODE_HALT) |-> (npush == 2'd0))
        else $error("result produced while halted");

    a_pair_badch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (npush == 2'd2) |-> (res_b.kind == KIND_BADCH && n_mode == MODE_HALT))
        else $error("second result of a byte must be a bad character");
endmodule
`default_nettype wire
